[design/iard_pkg.sv]
// Shared types and constants for the input axis ramp with deadzone block.
package iard_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_GAIN,
        ST_SCALE,
        ST_SUM
    } state_t;

    // Operand selection for the shared multiplier
    typedef enum logic [1:0] {
        MUL_STEP,
        MUL_GAIN,
        MUL_SCALE
    } mul_op_t;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_ACCEL_RATE        = 3'd0,
        REG_DECEL_RATE        = 3'd1,
        REG_STICK_THRESHOLD   = 3'd2,
        REG_STICK_GAIN        = 3'd3,
        REG_TRIGGER_THRESHOLD = 3'd4,
        REG_TRIGGER_GAIN      = 3'd5,
        REG_ANALOG_SCALE      = 3'd6,
        REG_CLAMP_ENABLE      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0]        accel_rate;
        logic [15:0]        decel_rate;
        logic [14:0]        stick_threshold;
        logic [15:0]        stick_gain;
        logic [14:0]        trigger_threshold;
        logic [15:0]        trigger_gain;
        logic signed [15:0] analog_scale;
        logic               clamp_enable;
    } cfg_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;
        logic    mul_en;
        mul_op_t mul_op;
        logic    ramp_upd;
        logic    out_load;
    } cmd_t;

    localparam logic [15:0] RESET_GAIN  = 16'd256;
    localparam logic [15:0] RESET_SCALE = 16'd256;

    localparam logic signed [24:0] RAMP_HI = 25'sd32767;
    localparam logic signed [24:0] RAMP_LO = -25'sd32767;

    localparam logic [22:0] ANALOG_ONE = 23'd32768;

    localparam logic signed [25:0] CLAMP_HI = 26'sd32768;
    localparam logic signed [25:0] CLAMP_LO = -26'sd32768;
    localparam logic signed [25:0] OUT_HI   = 26'sd8388607;
    localparam logic signed [25:0] OUT_LO   = -26'sd8388608;

endpackage

[design/iard_cfg.sv]
// Configuration register file for the input axis ramp block.
module iard_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [2:0]    wr_index,
    input  logic [15:0]   wr_data,
    output iard_pkg::cfg_t cfg
);
    import iard_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_ACCEL_RATE:        cfg_next.accel_rate        = wr_data;
                REG_DECEL_RATE:        cfg_next.decel_rate        = wr_data;
                REG_STICK_THRESHOLD:   cfg_next.stick_threshold   = wr_data[14:0];
                REG_STICK_GAIN:        cfg_next.stick_gain        = wr_data;
                REG_TRIGGER_THRESHOLD: cfg_next.trigger_threshold = wr_data[14:0];
                REG_TRIGGER_GAIN:      cfg_next.trigger_gain      = wr_data;
                REG_ANALOG_SCALE:      cfg_next.analog_scale      = wr_data;
                REG_CLAMP_ENABLE:      cfg_next.clamp_enable      = wr_data[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_rate        <= '0;
            cfg_reg.decel_rate        <= '0;
            cfg_reg.stick_threshold   <= '0;
            cfg_reg.stick_gain        <= RESET_GAIN;
            cfg_reg.trigger_threshold <= '0;
            cfg_reg.trigger_gain      <= RESET_GAIN;
            cfg_reg.analog_scale      <= RESET_SCALE;
            cfg_reg.clamp_enable      <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/iard_ctrl.sv]
// Sequencing controller: walks one word through the shared multiplier.
module iard_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output iard_pkg::cmd_t cmd
);
    import iard_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.mul_en   = 1'b0;
        cmd.mul_op   = MUL_STEP;
        cmd.ramp_upd = 1'b0;
        cmd.out_load = 1'b0;
        in_stall     = 1'b1;
        // output word leaves when taken
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_STEP;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.ramp_upd = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_op   = MUL_GAIN;
                state_next   = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_SCALE;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

[design/iard_dp.sv]
// Datapath: input latch, shared multiplier, ramp state, deadzone and output stage.
module iard_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  iard_pkg::cmd_t      cmd,
    input  iard_pkg::cfg_t      cfg,
    input  logic                positive_down,
    input  logic                negative_down,
    input  logic [15:0]         tick_time,
    input  logic signed [15:0]  raw_analog,
    input  logic                analog_is_trigger,
    output logic signed [23:0]  axis_level,
    output logic signed [15:0]  ramp
);
    import iard_pkg::*;

    logic               pos_reg;
    logic               neg_reg;
    logic [15:0]        tick_reg;
    logic signed [15:0] raw_reg;
    logic               trig_reg;
    logic signed [33:0] prod_reg;
    logic signed [33:0] prod_next;
    logic signed [15:0] ramp_reg;
    logic signed [15:0] ramp_next;
    logic signed [23:0] axis_reg;
    logic signed [23:0] axis_next;

    logic [14:0]        dz;
    logic [15:0]        gain;
    logic [15:0]        raw_neg;
    logic [14:0]        mag;
    logic               below;
    logic [14:0]        diff;
    logic               a_neg;
    logic [22:0]        mag_sc;
    logic [16:0]        a_mag;
    logic signed [16:0] a_val;
    logic [15:0]        rate;
    logic signed [16:0] op_a;
    logic signed [16:0] op_b;
    logic [22:0]        step;
    logic signed [24:0] ramp_wide;
    logic signed [24:0] ramp_sum;
    logic signed [25:0] sum;
    logic signed [25:0] lim;

    // input latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_reg  <= positive_down;
            neg_reg  <= negative_down;
            tick_reg <= tick_time;
            raw_reg  <= raw_analog;
            trig_reg <= analog_is_trigger;
        end
    end

    // magnitude and deadzone test
    always_comb
    begin
        dz      = trig_reg ? cfg.trigger_threshold : cfg.stick_threshold;
        gain    = trig_reg ? cfg.trigger_gain : cfg.stick_gain;
        raw_neg = 16'(-raw_reg);
        a_neg   = !trig_reg && raw_reg[15];
        if (trig_reg)
            mag = raw_reg[15] ? 15'd0 : raw_reg[14:0];
        else if (raw_reg[15])
            mag = (raw_reg == -16'sd32768) ? 15'h7fff : raw_neg[14:0];
        else
            mag = raw_reg[14:0];
        below = mag < dz;
        diff  = mag - dz;
    end

    // rescaled analog, valid while prod_reg holds (m - dz) * gain
    always_comb
    begin
        mag_sc = prod_reg[30:8];
        if (below)
            a_mag = 17'd0;
        else if (mag_sc > ANALOG_ONE)
            a_mag = ANALOG_ONE[16:0];
        else
            a_mag = mag_sc[16:0];
        a_val = a_neg ? -$signed(a_mag) : $signed(a_mag);
    end

    // shared multiplier operands
    always_comb
    begin
        rate = (pos_reg != neg_reg) ? cfg.accel_rate : cfg.decel_rate;
        case (cmd.mul_op)
            MUL_STEP:
            begin
                op_a = $signed({1'b0, rate});
                op_b = $signed({1'b0, tick_reg});
            end
            MUL_GAIN:
            begin
                op_a = $signed({2'b00, diff});
                op_b = $signed({1'b0, gain});
            end
            MUL_SCALE:
            begin
                op_a = a_val;
                op_b = {cfg.analog_scale[15], cfg.analog_scale};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod_next = op_a * op_b;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= prod_next;
    end

    // ramp update, prod_reg holds rate * tick_time
    always_comb
    begin
        step      = prod_reg[31:9];
        ramp_wide = 25'(ramp_reg);
        ramp_sum  = ramp_wide;
        if (pos_reg != neg_reg)
        begin
            if (pos_reg)
            begin
                ramp_sum = ramp_wide + $signed({2'b00, step});
                if (ramp_sum > RAMP_HI)
                    ramp_sum = RAMP_HI;
            end
            else
            begin
                ramp_sum = ramp_wide - $signed({2'b00, step});
                if (ramp_sum < RAMP_LO)
                    ramp_sum = RAMP_LO;
            end
        end
        else if (ramp_wide < 0)
        begin
            ramp_sum = ramp_wide + $signed({2'b00, step});
            if (ramp_sum > 0)
                ramp_sum = '0;
        end
        else if (ramp_wide > 0)
        begin
            ramp_sum = ramp_wide - $signed({2'b00, step});
            if (ramp_sum < 0)
                ramp_sum = '0;
        end
        ramp_next = ramp_sum[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ramp_reg <= '0;
        else if (cmd.ramp_upd)
            ramp_reg <= ramp_next;
    end

    // final sum, prod_reg holds a * analog_scale; >>> 8 floors
    always_comb
    begin
        sum = 26'(ramp_reg) + $signed(prod_reg[33:8]);
        lim = sum;
        if (cfg.clamp_enable)
        begin
            if (lim > CLAMP_HI)
                lim = CLAMP_HI;
            else if (lim < CLAMP_LO)
                lim = CLAMP_LO;
        end
        if (lim > OUT_HI)
            lim = OUT_HI;
        else if (lim < OUT_LO)
            lim = OUT_LO;
        axis_next = lim[23:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            axis_reg <= axis_next;
    end

    assign axis_level = axis_reg;
    assign ramp       = ramp_reg;

endmodule

[design/input_axis_ramp_deadzone.sv]
// Top level of the input axis ramp with deadzone block.
//
// One input word per frame tick: two digital flags, the tick time and one raw
// analog reading. Each word yields one output word, axis_level (Q9.15,
// clamped to +/-1.0 when clamp_enable is set, else saturated to 24 bits).
// Both data channels use valid/stall; a word moves when valid is high and
// stall is low. Config writes use cfg_valid/cfg_ready with cfg_index and
// cfg_data; the user must make them only while the block is idle, which the
// block itself does not enforce: cfg_ready is always 1. A word is taken in
// the idle state, then the single shared 17x17 multiplier is used three times
// in sequence (rate * tick, (magnitude - deadzone) * gain, analog * scale);
// the sum and limit stage then loads the output register and raises out_valid.
// in_stall is low only while the controller is idle. The output register
// decouples the sides: a new word is accepted while the last result waits,
// but if out_stall holds the previous result, the sequencer waits in its
// final step until the output register frees up.
// Reset clears the ramp to zero and loads register defaults
// (gains 256, analog_scale 256, clamp on, everything else zero).
module input_axis_ramp_deadzone (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               positive_down,
    input  logic               negative_down,
    input  logic [15:0]        tick_time,
    input  logic signed [15:0] raw_analog,
    input  logic               analog_is_trigger,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] axis_level,
    // config write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import iard_pkg::*;

    cfg_t               cfg;
    cmd_t               cmd;
    logic signed [15:0] ramp;

    assign cfg_ready = 1'b1;

    iard_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    iard_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    iard_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg               (cfg),
        .positive_down     (positive_down),
        .negative_down     (negative_down),
        .tick_time         (tick_time),
        .raw_analog        (raw_analog),
        .analog_is_trigger (analog_is_trigger),
        .axis_level        (axis_level),
        .ramp              (ramp)
    );

    // ramp never reaches the most negative code
    assert property (@(posedge clk) disable iff (!rst_n)
        ramp != -16'sd32768)
    else $error("ramp left its +/-1.0 range");

    // an accepted word has its result present after the STEP, GAIN, SCALE and SUM states
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> ##5 out_valid)
    else $error("result missing after accept");

    // no new word is taken in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("second word accepted while busy");

    // clamped output stays within one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cfg.clamp_enable) |->
            (axis_level <= 24'sd32768 && axis_level >= -24'sd32768))
    else $error("clamped output out of range");

endmodule

[tb/input_axis_ramp_deadzone_tb.sv]
// Self-checking testbench for the input axis ramp with deadzone block.
`timescale 1ns / 1ps

module input_axis_ramp_deadzone_tb;

    import iard_pkg::*;

    // Q9.15 limits used by the axis predictor
    localparam longint RAMP_FULL = 32767;
    localparam longint ONE_Q15   = 32768;
    localparam longint AXIS_MAX  = 8388607;
    localparam longint AXIS_MIN  = -8388608;
    // Cycles from input word to output word, with a little slack
    localparam int     LATENCY   = 5;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               positive_down;
    logic               negative_down;
    logic [15:0]        tick_time;
    logic signed [15:0] raw_analog;
    logic               analog_is_trigger;
    logic               out_valid;
    logic               out_stall;
    logic signed [23:0] axis_level;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;

    // Shadow copy of the register file and the kept ramp
    cfg_t               model_cfg;
    longint             ramp_q15;

    // Axis values still owed by the block, oldest first
    logic signed [23:0] axis_expected[$];

    int                 mismatch_count = 0;
    int                 stall_pct      = 0;  // share of stall runs on the output side
    int                 hold_request   = 0;  // cycles of forced output stall, 0 = none

    input_axis_ramp_deadzone dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .positive_down     (positive_down),
        .negative_down     (negative_down),
        .tick_time         (tick_time),
        .raw_analog        (raw_analog),
        .analog_is_trigger (analog_is_trigger),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .axis_level        (axis_level),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    //------------------------------------------------------------------
    // Axis predictor. Advances the ramp for one tick, then adds the
    // deadzoned, rescaled and scaled analog reading.
    //------------------------------------------------------------------
    function automatic logic signed [23:0] predict_axis_level(
        input logic               pos,
        input logic               neg,
        input logic [15:0]        t,
        input logic signed [15:0] raw,
        input logic               trig
    );
        longint r;
        longint step;
        longint raw_l;
        longint mag;
        longint dz;
        longint gain;
        longint an;
        longint total;
        bit     flip;
        r     = ramp_q15;
        raw_l = longint'(raw);
        flip  = 1'b0;
        if (pos != neg)
        begin
            step = (longint'(model_cfg.accel_rate) * longint'(t)) >>> 9;
            if (pos)
                r = (r + step > RAMP_FULL) ? RAMP_FULL : r + step;
            else
                r = (r - step < -RAMP_FULL) ? -RAMP_FULL : r - step;
        end
        else
        begin
            // no flag or both flags: decay, never crossing zero
            step = (longint'(model_cfg.decel_rate) * longint'(t)) >>> 9;
            if (r < 0)
                r = (r + step > 0) ? 0 : r + step;
            else if (r > 0)
                r = (r - step < 0) ? 0 : r - step;
        end
        ramp_q15 = r;

        if (trig)
        begin
            mag  = (raw_l < 0) ? 0 : raw_l;
            dz   = longint'(model_cfg.trigger_threshold);
            gain = longint'(model_cfg.trigger_gain);
        end
        else
        begin
            flip = (raw_l < 0);
            if (raw_l == -32768)
                mag = 32767;
            else
                mag = flip ? -raw_l : raw_l;
            dz   = longint'(model_cfg.stick_threshold);
            gain = longint'(model_cfg.stick_gain);
        end
        if (mag < dz)
            an = 0;
        else
        begin
            an = ((mag - dz) * gain) >>> 8;
            if (an > ONE_Q15)
                an = ONE_Q15;
        end
        if (flip)
            an = -an;

        // arithmetic shift gives the floor of the division by 256
        total = r + ((an * longint'($signed(model_cfg.analog_scale))) >>> 8);
        if (model_cfg.clamp_enable)
        begin
            if (total > ONE_Q15)
                total = ONE_Q15;
            if (total < -ONE_Q15)
                total = -ONE_Q15;
        end
        if (total > AXIS_MAX)
            total = AXIS_MAX;
        if (total < AXIS_MIN)
            total = AXIS_MIN;
        return total[23:0];
    endfunction

    task automatic report_mismatch(input string what, input logic signed [23:0] want,
                                   input logic signed [23:0] got);
        $display("ERROR at %0t: %s: expected %0d, got %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    //------------------------------------------------------------------
    // Output checker: every accepted word is matched against the oldest
    // prediction. Sampled right after the edge, so it sees the values
    // the block saw.
    //------------------------------------------------------------------
    always @(posedge clk)
    begin : axis_check
        logic signed [23:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (axis_expected.size() == 0)
                report_mismatch("axis_level word with none pending", '0, axis_level);
            else
            begin
                want = axis_expected.pop_front();
                if (axis_level !== want)
                    report_mismatch("axis_level", want, axis_level);
            end
        end
    end

    //------------------------------------------------------------------
    // Output stall generator: random on/off runs, plus a long forced
    // hold-off on request so the block backs up into its input side.
    //------------------------------------------------------------------
    initial
    begin : stall_gen
        int   run;
        int   hold;
        logic level;
        out_stall = 1'b0;
        run       = 0;
        level     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold         = hold_request;
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                run = 0;
            end
            else
            begin
                if (run == 0)
                begin
                    level = ($urandom_range(0, 99) < stall_pct);
                    run   = $urandom_range(1, 8);
                end
                run--;
                out_stall <= level;
            end
        end
    end

    //------------------------------------------------------------------
    // Send one input word; predicts its axis value once accepted.
    // Leaves in_valid high so back-to-back words need no bubble.
    //------------------------------------------------------------------
    task automatic send_word(input logic pos, input logic neg, input logic [15:0] t,
                             input logic signed [15:0] raw, input logic trig);
        in_valid          <= 1'b1;
        positive_down     <= pos;
        negative_down     <= neg;
        tick_time         <= t;
        raw_analog        <= raw;
        analog_is_trigger <= trig;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        axis_expected.push_back(predict_axis_level(pos, neg, t, raw, trig));
    endtask

    // Stop sending and wait until every owed word has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (axis_expected.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 1) @(posedge clk);
    endtask

    // One register write; cfg_valid stays up for the next write
    task automatic write_reg(input reg_idx_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            REG_ACCEL_RATE:        model_cfg.accel_rate        = data;
            REG_DECEL_RATE:        model_cfg.decel_rate        = data;
            REG_STICK_THRESHOLD:   model_cfg.stick_threshold   = data[14:0];
            REG_STICK_GAIN:        model_cfg.stick_gain        = data;
            REG_TRIGGER_THRESHOLD: model_cfg.trigger_threshold = data[14:0];
            REG_TRIGGER_GAIN:      model_cfg.trigger_gain      = data;
            REG_ANALOG_SCALE:      model_cfg.analog_scale      = data;
            REG_CLAMP_ENABLE:      model_cfg.clamp_enable      = data[0];
            default:               ;
        endcase
    endtask

    // Rewrite the whole register file while the block is idle.
    // Values go out at full 16 bits so narrow registers see spare bits.
    task automatic set_config(input logic [15:0] accel, input logic [15:0] decel,
                              input logic [15:0] stick_dz, input logic [15:0] stick_g,
                              input logic [15:0] trig_dz, input logic [15:0] trig_g,
                              input logic [15:0] scale, input logic [15:0] clamp);
        wait_idle();
        write_reg(REG_ACCEL_RATE, accel);
        write_reg(REG_DECEL_RATE, decel);
        write_reg(REG_STICK_THRESHOLD, stick_dz);
        write_reg(REG_STICK_GAIN, stick_g);
        write_reg(REG_TRIGGER_THRESHOLD, trig_dz);
        write_reg(REG_TRIGGER_GAIN, trig_g);
        write_reg(REG_ANALOG_SCALE, scale);
        write_reg(REG_CLAMP_ENABLE, clamp);
        cfg_valid <= 1'b0;
    endtask

    // Random register values, weighted toward the edges
    function automatic logic [15:0] rand_rate();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, 4000));
        endcase
    endfunction

    function automatic logic [15:0] rand_deadzone();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'd32766;
            2:       return 16'($urandom);             // spare top bit may be set
            default: return 16'($urandom_range(0, 12000));
        endcase
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'($urandom_range(1, 255));
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(256, 2048));
        endcase
    endfunction

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Register reset values: no ramp movement, unit analog path, clamp on
    task automatic test_reset_defaults();
        stall_pct = 30;
        send_word(1'b1, 1'b0, 16'hFFFF, 16'sh7FFF, 1'b0);   // full stick, accel 0
        send_word(1'b0, 1'b0, 16'd1092, -16'sd32768, 1'b0); // most negative stick
        send_word(1'b0, 1'b1, 16'd0, -16'sd5, 1'b1);        // negative trigger reads 0
        send_word(1'b1, 1'b1, 16'd1000, 16'sh7FFF, 1'b1);   // full trigger
    endtask

    // Ramp rise to both limits, decay with no and both flags, zero tick
    task automatic test_ramp_limits();
        set_config(16'hFFFF, 16'd300, 16'h0000, 16'd256, 16'h0000, 16'd256, 16'd256, 16'd1);
        send_word(1'b1, 1'b0, 16'hFFFF, 16'sd0, 1'b0);      // ramp pins at +full
        send_word(1'b1, 1'b0, 16'd100, 16'sh7FFF, 1'b0);    // sum clamps at +1.0
        send_word(1'b1, 1'b1, 16'd1092, 16'sd0, 1'b0);      // both flags decay
        send_word(1'b0, 1'b0, 16'd0, 16'sd0, 1'b0);         // zero tick, no change
        send_word(1'b0, 1'b1, 16'hFFFF, 16'sd0, 1'b0);      // ramp pins at -full
        send_word(1'b0, 1'b1, 16'd10, -16'sd32768, 1'b0);   // sum clamps at -1.0
        send_word(1'b0, 1'b0, 16'hFFFF, 16'sd0, 1'b0);      // big decay stops at zero
        send_word(1'b0, 1'b0, 16'd500, 16'sd0, 1'b0);       // zero ramp stays zero
        set_config(16'd100, 16'hFFFF, 16'h0000, 16'd256, 16'h0000, 16'd256, 16'd256, 16'd1);
        send_word(1'b1, 1'b0, 16'd1000, 16'sd0, 1'b0);      // small rise
        send_word(1'b1, 1'b1, 16'd1, 16'sd0, 1'b0);         // decay step truncates
    endtask

    // Deadzone edges, odd gains, negative scale, floor rounding, no clamp
    task automatic test_deadzone_gain();
        // stick deadzone written with the spare bit set reads back as 32767
        set_config(16'h0000, 16'h0000, 16'hFFFF, 16'd256, 16'h83E8, 16'h0000,
                   16'h8000, 16'hFFFE);
        send_word(1'b0, 1'b0, 16'd0, 16'sh7FFF, 1'b0);      // full deadzone -> 0
        send_word(1'b0, 1'b0, 16'd0, 16'sh7FFF, 1'b1);      // gain 0 -> 0
        send_word(1'b0, 1'b0, 16'd0, 16'sd999, 1'b1);       // just under deadzone
        set_config(16'h0000, 16'h0000, 16'd100, 16'hFFFF, 16'd32766, 16'd100,
                   16'h8000, 16'h0000);
        send_word(1'b0, 1'b0, 16'd0, 16'sh7FFF, 1'b0);      // analog saturates at 1.0
        send_word(1'b0, 1'b0, 16'd0, -16'sd32768, 1'b0);
        send_word(1'b0, 1'b0, 16'd0, -16'sd101, 1'b0);      // one step past deadzone
        send_word(1'b0, 1'b0, 16'd0, -16'sd99, 1'b0);
        send_word(1'b0, 1'b0, 16'd0, 16'sh7FFF, 1'b1);      // gain below unity
        set_config(16'h0000, 16'h0000, 16'd100, 16'hFFFF, 16'h0000, 16'd256,
                   16'hFFFF, 16'd1);
        send_word(1'b0, 1'b0, 16'd0, -16'sd101, 1'b0);      // rounds toward -inf
        send_word(1'b0, 1'b0, 16'd0, 16'sd101, 1'b0);
    endtask

    // Long output hold-off while words keep coming, so in_stall rises
    task automatic test_backpressure();
        int n;
        set_config(16'd2000, 16'd1500, 16'd3000, 16'd300, 16'd2000, 16'd280, 16'd200, 16'd1);
        stall_pct    = 0;
        hold_request = 150;
        for (n = 0; n < 16; n++)
            send_word(n[0], n[1], 16'($urandom_range(500, 3000)), 16'($urandom), n[2]);
    endtask

    // Phases of random traffic: digital flags held for runs of ticks,
    // analog readings biased to the deadzone edge and full scale
    task automatic test_random_traffic();
        int          phase;
        int          n;
        int          burst_left;
        int          gap_max;
        int          gap;
        int          hold_run;
        int          raw_i;
        int          dz;
        logic [1:0]  flags;
        logic [15:0] tick;
        logic        trig;
        hold_run = 0;
        flags    = 2'b00;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_config(16'hFFFF, 16'hFFFF, 16'd32766, 16'hFFFF, 16'd32766, 16'hFFFF,
                              16'h7FFF, 16'd1);
                1: set_config(16'h0000, 16'h0000, 16'h0000, 16'd256, 16'h0000, 16'd256,
                              16'h8000, 16'd0);
                default: set_config(rand_rate(), rand_rate(), rand_deadzone(), rand_gain(),
                                    rand_deadzone(), rand_gain(), 16'($urandom),
                                    16'($urandom));
            endcase
            // phase 2 runs flat out on both sides
            gap_max    = (phase == 2) ? 0 : $urandom_range(1, 10);
            stall_pct  = (phase == 2) ? 0 : $urandom_range(10, 70);
            burst_left = $urandom_range(1, 16);
            for (n = 0; n < 215; n++)
            begin
                if (hold_run == 0)
                begin
                    flags    = 2'($urandom_range(0, 3));
                    hold_run = $urandom_range(1, 30);
                end
                hold_run--;
                case ($urandom_range(0, 9))
                    0:       tick = 16'h0000;
                    1:       tick = 16'hFFFF;
                    2, 3:    tick = 16'($urandom);
                    default: tick = 16'($urandom_range(500, 3000));
                endcase
                trig = 1'($urandom_range(0, 1));
                dz   = trig ? int'(model_cfg.trigger_threshold)
                            : int'(model_cfg.stick_threshold);
                case ($urandom_range(0, 7))
                    0: raw_i = 32767;
                    1: raw_i = -32768;
                    2:
                    begin
                        raw_i = dz + int'($urandom_range(0, 4)) - 2;
                        if ($urandom_range(0, 1))
                            raw_i = -raw_i;
                    end
                    default: raw_i = int'($urandom_range(0, 65535)) - 32768;
                endcase
                send_word(flags[0], flags[1], tick, 16'(raw_i), trig);
                burst_left--;
                if (burst_left == 0)
                begin
                    gap = $urandom_range(0, gap_max);
                    if (gap > 0)
                    begin
                        in_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 16);
                end
            end
        end
    endtask

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        positive_down     = 1'b0;
        negative_down     = 1'b0;
        tick_time         = '0;
        raw_analog        = '0;
        analog_is_trigger = 1'b0;
        cfg_valid         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;

        // shadow registers start at the block's reset values
        model_cfg.accel_rate        = '0;
        model_cfg.decel_rate        = '0;
        model_cfg.stick_threshold   = '0;
        model_cfg.stick_gain        = RESET_GAIN;
        model_cfg.trigger_threshold = '0;
        model_cfg.trigger_gain      = RESET_GAIN;
        model_cfg.analog_scale      = RESET_SCALE;
        model_cfg.clamp_enable      = 1'b1;
        ramp_q15                    = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_ramp_limits();
        test_deadzone_gain();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[input_axis_ramp_deadzone.f]
design/iard_pkg.sv
design/iard_cfg.sv
design/iard_ctrl.sv
design/iard_dp.sv
design/input_axis_ramp_deadzone.sv
tb/input_axis_ramp_deadzone_tb.sv
